// ===== rtl/chr_pkg.sv =====
// chr_pkg: shared constants, command codes, state type and control structs
// for the command history ring; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package chr_pkg;

    localparam int ENTRIES    = 20;
    localparam int LINE_BYTES = 128;
    localparam int WORDS      = LINE_BYTES / 4;
    localparam int MAX_LEN    = LINE_BYTES - 1;

    localparam int SLOT_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int LEN_W  = $clog2(LINE_BYTES);
    localparam int WIDX_W = $clog2(WORDS);
    localparam int ADDR_W = $clog2(ENTRIES * WORDS);

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 32;
    localparam int BCNT_W  = 3;
    localparam int SLOTN_W = 5;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_COMMIT = 2'd1,
        CMD_UP     = 2'd2,
        CMD_DOWN   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY,
        ST_COPY_END,
        ST_READ,
        ST_LOAD,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic stg_write;
        logic copy_start;
        logic copy_read;
        logic copy_done;
        logic browse_start;
        logic rd_first;
        logic rd_next;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic stg_empty;
        logic copy_last;
        logic out_last;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/chr_dpath.sv =====
// chr_dpath: staging buffer, line store, ring pointers and output register
// depends on chr_pkg; driven by chr_ctrl commands
`timescale 1ns / 1ps
`default_nettype none

module chr_dpath
    import chr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_in_cmd,
    input  wire logic [BYTE_W-1:0]     i_in_byte,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    output logic [WORD_W-1:0]          o_text_word,
    output logic [BCNT_W-1:0]          o_byte_count,
    output logic                       o_last_word,
    output logic                       o_empty_line,
    output logic [SLOTN_W-1:0]         o_slot_number
);

    // memories
    logic [WORD_W-1:0] r_stg_mem  [WORDS];
    logic [WORD_W-1:0] r_line_mem [ENTRIES*WORDS];
    logic [LEN_W-1:0]  r_line_len [ENTRIES];

    logic [WORD_W-1:0] r_stg_rd;
    logic [WORD_W-1:0] r_line_rd;

    // ring and staging state
    logic [LEN_W-1:0]  r_stg_len,  n_stg_len;
    logic [SLOT_W-1:0] r_head,     n_head;
    logic [CNT_W-1:0]  r_count,    n_count;
    logic [SLOT_W-1:0] r_bslot,    n_bslot;
    logic              r_browsing, n_browsing;

    // per-operation state
    logic [SLOT_W-1:0] r_cur_slot, n_cur_slot;
    logic [LEN_W-1:0]  r_len_cur,  n_len_cur;
    logic              r_empty,    n_empty;
    logic [WIDX_W-1:0] r_word_idx, n_word_idx;
    logic [WIDX_W-1:0] r_wr_idx;
    logic              r_wr_pend;

    // output register
    logic [WORD_W-1:0]  r_out_word;
    logic [BCNT_W-1:0]  r_out_cnt;
    logic               r_out_last;
    logic               r_out_empty;
    logic [SLOTN_W-1:0] r_out_slot;

    logic [SLOT_W-1:0] newest;
    logic [SLOT_W-1:0] oldest;
    logic [SLOT_W-1:0] slot_prev;
    logic [SLOT_W-1:0] slot_next;
    logic [LEN_W-1:0]  len_m1;
    logic [WIDX_W-1:0] last_idx;
    logic              at_last;
    logic [WIDX_W-1:0] rd_idx;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [BCNT_W-1:0] word_cnt;
    logic [WORD_W-1:0] masked_word;
    logic              stg_accept;

    assign newest    = (r_head == '0) ? SLOT_W'(ENTRIES - 1) : r_head - 1'b1;
    assign slot_prev = (r_bslot == '0) ? SLOT_W'(ENTRIES - 1) : r_bslot - 1'b1;
    assign slot_next = (r_bslot == SLOT_W'(ENTRIES - 1)) ? '0 : r_bslot + 1'b1;

    always_comb begin
        if (CNT_W'(r_head) >= r_count) begin
            oldest = SLOT_W'(CNT_W'(r_head) - r_count);
        end else begin
            oldest = SLOT_W'(CNT_W'(r_head) + CNT_W'(ENTRIES) - r_count);
        end
    end

    assign len_m1   = r_len_cur - LEN_W'(1);
    assign last_idx = WIDX_W'(len_m1 >> 2);
    assign at_last  = (r_word_idx == last_idx);

    assign rd_idx  = i_cmd.rd_next ? r_word_idx + 1'b1 : r_word_idx;
    assign rd_addr = ADDR_W'(r_cur_slot) * ADDR_W'(WORDS) + ADDR_W'(rd_idx);
    assign wr_addr = ADDR_W'(r_cur_slot) * ADDR_W'(WORDS) + ADDR_W'(r_wr_idx);

    assign stg_accept = i_cmd.stg_write && (i_in_byte != '0)
                        && (r_stg_len < LEN_W'(MAX_LEN));

    // byte count of the word now in the line read register
    always_comb begin
        if (at_last && (r_len_cur[1:0] != 2'd0)) begin
            word_cnt = BCNT_W'(r_len_cur[1:0]);
        end else begin
            word_cnt = BCNT_W'(4);
        end
        for (int b = 0; b < 4; b++) begin
            masked_word[BYTE_W*b +: BYTE_W] =
                (BCNT_W'(b) < word_cnt) ? r_line_rd[BYTE_W*b +: BYTE_W] : '0;
        end
    end

    always_comb begin
        n_stg_len  = r_stg_len;
        n_head     = r_head;
        n_count    = r_count;
        n_bslot    = r_bslot;
        n_browsing = r_browsing;
        n_cur_slot = r_cur_slot;
        n_len_cur  = r_len_cur;
        n_empty    = r_empty;
        n_word_idx = r_word_idx;

        if (stg_accept) begin
            n_stg_len = r_stg_len + 1'b1;
        end

        if (i_cmd.copy_start) begin
            n_cur_slot = r_head;
            n_len_cur  = r_stg_len;
            n_word_idx = '0;
        end

        if (i_cmd.copy_read && !at_last) begin
            n_word_idx = r_word_idx + 1'b1;
        end

        if (i_cmd.copy_done) begin
            n_head     = (r_head == SLOT_W'(ENTRIES - 1)) ? '0 : r_head + 1'b1;
            n_count    = (r_count == CNT_W'(ENTRIES)) ? r_count : r_count + 1'b1;
            n_browsing = 1'b0;
            n_stg_len  = '0;
        end

        if (i_cmd.browse_start) begin
            n_word_idx = '0;
            n_empty    = 1'b0;
            if (i_in_cmd == CMD_UP) begin
                if (r_count == '0) begin
                    n_empty = 1'b1;
                end else if (!r_browsing) begin
                    n_bslot    = newest;
                    n_browsing = 1'b1;
                end else if (r_bslot != oldest) begin
                    n_bslot = slot_prev;
                end
            end else begin
                if ((r_count == '0) || !r_browsing) begin
                    n_empty = 1'b1;
                end else if (r_bslot == newest) begin
                    n_browsing = 1'b0;
                    n_empty    = 1'b1;
                end else begin
                    n_bslot = slot_next;
                end
            end
            n_cur_slot = n_bslot;
            n_len_cur  = r_line_len[n_bslot];
        end

        if (i_cmd.rd_next) begin
            n_word_idx = r_word_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_len  <= '0;
            r_head     <= '0;
            r_count    <= '0;
            r_bslot    <= '0;
            r_browsing <= 1'b0;
            r_wr_pend  <= 1'b0;
        end else begin
            r_stg_len  <= n_stg_len;
            r_head     <= n_head;
            r_count    <= n_count;
            r_bslot    <= n_bslot;
            r_browsing <= n_browsing;
            r_wr_pend  <= i_cmd.copy_read;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_slot <= n_cur_slot;
        r_len_cur  <= n_len_cur;
        r_empty    <= n_empty;
        r_word_idx <= n_word_idx;
        if (i_cmd.copy_read) begin
            r_wr_idx <= r_word_idx;
        end
        if (i_cmd.copy_done) begin
            r_line_len[r_cur_slot] <= r_stg_len;
        end
    end

    // staging buffer: byte lane writes, word reads for the commit copy
    always_ff @(posedge i_clk) begin
        if (stg_accept) begin
            r_stg_mem[r_stg_len[LEN_W-1:2]][{r_stg_len[1:0], 3'b000} +: BYTE_W] <= i_in_byte;
        end
        if (i_cmd.copy_read) begin
            r_stg_rd <= r_stg_mem[r_word_idx];
        end
    end

    // line store: copy writes in the cycle after the staging read
    always_ff @(posedge i_clk) begin
        if (r_wr_pend) begin
            r_line_mem[wr_addr] <= r_stg_rd;
        end
        if (i_cmd.rd_first || i_cmd.rd_next) begin
            r_line_rd <= r_line_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_empty) begin
                r_out_word  <= '0;
                r_out_cnt   <= '0;
                r_out_last  <= 1'b1;
                r_out_empty <= 1'b1;
                r_out_slot  <= '0;
            end else begin
                r_out_word  <= masked_word;
                r_out_cnt   <= word_cnt;
                r_out_last  <= at_last;
                r_out_empty <= 1'b0;
                r_out_slot  <= SLOTN_W'(r_cur_slot);
            end
        end
    end

    assign o_stat.stg_empty = (r_stg_len == '0);
    assign o_stat.copy_last = at_last;
    assign o_stat.out_last  = r_out_last;

    assign o_text_word   = r_out_word;
    assign o_byte_count  = r_out_cnt;
    assign o_last_word   = r_out_last;
    assign o_empty_line  = r_out_empty;
    assign o_slot_number = r_out_slot;

endmodule

`default_nettype wire

// ===== rtl/chr_ctrl.sv =====
// chr_ctrl: sequencer for append, commit copy and browse streaming
// depends on chr_pkg; commands chr_dpath
`timescale 1ns / 1ps
`default_nettype none

module chr_ctrl
    import chr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_cmd     i_in_cmd,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_in_cmd)
                        CMD_APPEND: begin
                            o_cmd.stg_write = 1'b1;
                        end
                        CMD_COMMIT: begin
                            // empty commit is dropped
                            if (!i_stat.stg_empty) begin
                                o_cmd.copy_start = 1'b1;
                                n_state          = ST_COPY;
                            end
                        end
                        CMD_UP, CMD_DOWN: begin
                            o_cmd.browse_start = 1'b1;
                            n_state            = ST_READ;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_COPY: begin
                o_cmd.copy_read = 1'b1;
                if (i_stat.copy_last) begin
                    n_state = ST_COPY_END;
                end
            end
            ST_COPY_END: begin
                // last line word is written this cycle
                o_cmd.copy_done = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_READ: begin
                o_cmd.rd_first = 1'b1;
                n_state        = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.out_load = 1'b1;
                n_state        = ST_SEND;
            end
            ST_SEND: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_stat.out_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                        n_state       = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/command_history_ring.sv =====
// commit copies one line word per cycle from the staging buffer into the line store
// browse: each beat goes through a line store read, then an output register load,
// then is held in the send state until the sink is ready
// an empty line is sent as a single beat; one item at a time
// reset: synchronous active low, clears staging length, head, count and browse state
// stored lines and staging bytes are not cleared and are read only once written
`timescale 1ns / 1ps
`default_nettype none

module command_history_ring
    import chr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [1:0]            s_axis_tuser,   // [1:0] cmd
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [31:0] text_word, [34:32] byte_count,
                                                       // [39:35] slot_number
    output logic                       m_axis_tlast,   // last_word
    output logic                       m_axis_tuser    // [0] empty_line
);

    t_cmd     in_cmd;
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    logic [WORD_W-1:0]  text_word;
    logic [BCNT_W-1:0]  byte_count;
    logic [SLOTN_W-1:0] slot_number;

    assign in_cmd = t_cmd'(s_axis_tuser);

    chr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_cmd    (in_cmd),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    chr_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_cmd      (in_cmd),
        .i_in_byte     (s_axis_tdata),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .o_text_word   (text_word),
        .o_byte_count  (byte_count),
        .o_last_word   (m_axis_tlast),
        .o_empty_line  (m_axis_tuser),
        .o_slot_number (slot_number)
    );

    assign m_axis_tdata = {slot_number, byte_count, text_word};

`ifndef SYNTHESIS
    // input side and output side never open together
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result beat is pending");

    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (m_axis_tlast && (m_axis_tdata[34:32] == 3'd0)))
        else $error("empty line beat is not a single zero-count beat");

    a_word_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |->
            ((m_axis_tdata[34:32] != 3'd0) && (m_axis_tdata[34:32] <= 3'd4)))
        else $error("line beat with bad byte count");

    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("not ready for input after the last beat of a line");
`endif

endmodule

`default_nettype wire

// ===== bench/command_history_ring_tb.sv =====
// command_history_ring_tb: self-checking bench for the command history ring
// drives append/commit/browse beats with random gaps and stalls, predicts every
// output beat in a local copy of the ring; depends on chr_pkg and command_history_ring
`timescale 1ns / 1ps

module command_history_ring_tb;
    import chr_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_ITEMS = 330;
    localparam int MIN_COMMITS = 24;

    typedef struct {
        t_cmd       cmd;
        logic [7:0] data_byte;
    } cmd_beat_t;

    typedef struct {
        logic [31:0] text_word;
        logic [2:0]  byte_count;
        logic        last_word;
        logic        empty_line;
        logic [4:0]  slot_number;
    } line_beat_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [7:0] data_byte
    logic [1:0]            s_axis_tuser = '0;   // [1:0] cmd
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // [31:0] text_word, [34:32] byte_count,
                                                // [39:35] slot_number
    logic                  m_axis_tlast;        // last_word
    logic                  m_axis_tuser;        // [0] empty_line

    command_history_ring uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // predicted ring contents
    logic [7:0] ring_text [ENTRIES][LINE_BYTES];
    int         ring_len [ENTRIES];
    logic [7:0] stage_text [LINE_BYTES];
    int         stage_len = 0;
    int         ring_head = 0;
    int         ring_count = 0;
    int         browse_pos = 0;
    bit         browse_on = 1'b0;

    cmd_beat_t  pending_cmds[$];
    line_beat_t expected_beats[$];

    int  errors = 0;
    int  cycle_count = 0;
    bit  in_fire = 1'b0;
    bit  out_fire = 1'b0;
    int  send_gap = 0;
    int  send_calm = 0;
    int  recv_wait = 0;
    int  recv_calm = 0;

    // stimulus bookkeeping
    int  gen_stage_len = 0;
    int  useful_items = 0;
    int  commit_total = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // idle length per beat; now and then a run of back-to-back beats
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm = $urandom_range(10, 40);
        return $urandom_range(0, 7);
    endfunction

    function automatic void push_empty();
        line_beat_t b;
        b.text_word   = '0;
        b.byte_count  = '0;
        b.last_word   = 1'b1;
        b.empty_line  = 1'b1;
        b.slot_number = '0;
        expected_beats.push_back(b);
    endfunction

    function automatic void stream_line(input int slot);
        line_beat_t b;
        int len;
        int pos;
        int n;
        len = ring_len[slot];
        pos = 0;
        if (len == 0) begin
            push_empty();
            return;
        end
        while (pos < len) begin
            b.text_word = '0;
            n = 0;
            while (n < 4 && pos < len) begin
                b.text_word = b.text_word | (32'(ring_text[slot][pos]) << (8 * n));
                n++;
                pos++;
            end
            b.byte_count  = 3'(n);
            b.last_word   = (pos >= len);
            b.empty_line  = 1'b0;
            b.slot_number = 5'(slot);
            expected_beats.push_back(b);
        end
    endfunction

    function automatic void predict_item(input t_cmd cmd, input logic [7:0] data);
        int oldest;
        int newest;
        case (cmd)
            CMD_APPEND: begin
                if (data != 8'd0 && stage_len < MAX_LEN) begin
                    stage_text[stage_len] = data;
                    stage_len++;
                end
            end
            CMD_COMMIT: begin
                if (stage_len != 0) begin
                    for (int i = 0; i < stage_len; i++)
                        ring_text[ring_head][i] = stage_text[i];
                    ring_len[ring_head] = stage_len;
                    ring_head = (ring_head + 1) % ENTRIES;
                    if (ring_count < ENTRIES)
                        ring_count++;
                    browse_on = 1'b0;
                    stage_len = 0;
                end
            end
            CMD_UP: begin
                if (ring_count == 0) begin
                    push_empty();
                end else begin
                    if (!browse_on) begin
                        browse_pos = (ring_head + ENTRIES - 1) % ENTRIES;
                        browse_on = 1'b1;
                    end else begin
                        oldest = (ring_head + ENTRIES - ring_count) % ENTRIES;
                        if (browse_pos != oldest)
                            browse_pos = (browse_pos + ENTRIES - 1) % ENTRIES;
                    end
                    stream_line(browse_pos);
                end
            end
            default: begin
                newest = (ring_head + ENTRIES - 1) % ENTRIES;
                if (ring_count == 0 || !browse_on) begin
                    push_empty();
                end else if (browse_pos == newest) begin
                    // stepping past the newest entry leaves browse mode
                    browse_on = 1'b0;
                    push_empty();
                end else begin
                    browse_pos = (browse_pos + 1) % ENTRIES;
                    stream_line(browse_pos);
                end
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %h, got %h", name, exp_val, act_val);
            errors++;
        end
    endfunction

    function automatic void check_beat();
        line_beat_t b;
        if (expected_beats.size() == 0) begin
            $error("output beat with nothing expected: tdata %h", m_axis_tdata);
            errors++;
            return;
        end
        b = expected_beats.pop_front();
        check_field("text_word", b.text_word, m_axis_tdata[31:0]);
        check_field("byte_count", 32'(b.byte_count), 32'(m_axis_tdata[34:32]));
        check_field("slot_number", 32'(b.slot_number), 32'(m_axis_tdata[39:35]));
        check_field("last_word", 32'(b.last_word), 32'(m_axis_tlast));
        check_field("empty_line", 32'(b.empty_line), 32'(m_axis_tuser));
    endfunction

    // monitor: both handshakes sampled at the rising edge
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        in_fire <= s_axis_tvalid && s_axis_tready;
        out_fire <= m_axis_tvalid && m_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            predict_item(t_cmd'(s_axis_tuser), s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_beat();
    end

    // command driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!(s_axis_tvalid && !in_fire)) begin
            if (send_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap--;
            end else if (pending_cmds.size() > 0) begin
                s_axis_tdata  <= pending_cmds[0].data_byte;
                s_axis_tuser  <= pending_cmds[0].cmd;
                s_axis_tvalid <= 1'b1;
                void'(pending_cmds.pop_front());
                send_gap = draw_gap(send_calm);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output sink with random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (out_fire)
                recv_wait = draw_gap(recv_calm);
            if (recv_wait > 0) begin
                m_axis_tready <= 1'b0;
                recv_wait--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic void add_cmd(input t_cmd cmd, input logic [7:0] data);
        cmd_beat_t c;
        c.cmd = cmd;
        c.data_byte = data;
        pending_cmds.push_back(c);
        case (cmd)
            CMD_APPEND: begin
                if (data != 8'd0 && gen_stage_len < MAX_LEN) begin
                    gen_stage_len++;
                    useful_items++;
                end
            end
            CMD_COMMIT: begin
                if (gen_stage_len > 0) begin
                    gen_stage_len = 0;
                    useful_items++;
                    commit_total++;
                end
            end
            default: useful_items++;
        endcase
    endfunction

    function automatic void add_line(input int len, input int zero_odds);
        for (int i = 0; i < len; i++)
            add_cmd(CMD_APPEND, ($urandom_range(0, zero_odds) == 0) ? 8'd0
                                                                   : 8'($urandom_range(1, 255)));
        add_cmd(CMD_COMMIT, 8'($urandom));
    endfunction

    initial begin
        int pick;
        int n;
        int line_idx;
        bit all_up;

        // empty ring, zero byte, empty commit
        add_cmd(CMD_UP, 8'h00);
        add_cmd(CMD_DOWN, 8'hFF);
        add_cmd(CMD_APPEND, 8'h00);
        add_cmd(CMD_COMMIT, 8'h00);
        // five-byte line with extreme values and a dropped zero in the middle
        add_cmd(CMD_APPEND, 8'hFF);
        add_cmd(CMD_APPEND, 8'h01);
        add_cmd(CMD_APPEND, 8'h80);
        add_cmd(CMD_APPEND, 8'h7F);
        add_cmd(CMD_APPEND, 8'h00);
        add_cmd(CMD_APPEND, 8'h55);
        add_cmd(CMD_COMMIT, 8'hAA);
        add_cmd(CMD_APPEND, 8'hAA);
        add_cmd(CMD_COMMIT, 8'h00);
        // browse down before browsing, then up past the oldest and down past the newest
        add_cmd(CMD_DOWN, 8'h00);
        add_cmd(CMD_UP, 8'h00);
        add_cmd(CMD_UP, 8'h00);
        add_cmd(CMD_UP, 8'h00);
        add_cmd(CMD_DOWN, 8'h00);
        add_cmd(CMD_DOWN, 8'h00);
        add_cmd(CMD_DOWN, 8'h00);
        // staging while browsing; commit ends browsing
        add_cmd(CMD_APPEND, 8'h31);
        add_cmd(CMD_UP, 8'h00);
        add_cmd(CMD_COMMIT, 8'h00);
        add_cmd(CMD_DOWN, 8'h00);
        add_cmd(CMD_UP, 8'h00);

        useful_items = 0;
        line_idx = 0;
        while (useful_items < RANDOM_ITEMS || commit_total < MIN_COMMITS) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                // one full-length line that overflows the staging buffer, one medium
                if (line_idx == 12)
                    add_line($urandom_range(127, 135), 40);
                else if (line_idx == 30)
                    add_line($urandom_range(20, 60), 20);
                else
                    add_line($urandom_range(1, 8), 19);
                line_idx++;
            end else if (pick <= 8) begin
                all_up = ($urandom_range(0, 7) == 0);
                n = all_up ? $urandom_range(15, 24) : $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    add_cmd((all_up || $urandom_range(0, 2) != 0) ? CMD_UP : CMD_DOWN,
                            8'($urandom));
            end else begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    add_cmd(t_cmd'($urandom_range(0, 3)),
                            ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom));
            end
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || s_axis_tvalid || expected_beats.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0 && expected_beats.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $error("timeout with %0d beats still expected", expected_beats.size());
        $display("Verification failed");
        $finish;
    end

endmodule
